// ----- design/mmvg_pkg.sv -----
package mmvg_pkg;

  // Value and random widths
  localparam int VAL_W  = 16;
  localparam int RND_W  = 32;
  localparam int SPAN_W = VAL_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd4;

  // Divider: one quotient bit per cycle over the random word
  localparam int DIV_STEPS = RND_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    MODE_CONST  = 2'd0,
    MODE_WRAP   = 2'd1,
    MODE_PONG   = 2'd2,
    MODE_RANDOM = 2'd3
  } mode_t;

  // Controller to datapath
  typedef struct packed {
    logic take;      // input beat accepted this cycle
    logic div_step;  // one restoring-division step
    logic out_load;  // move the finished result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic random_mode;
  } sts_t;

endpackage

// ----- design/mmvg_ctrl.sv -----
module mmvg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  mmvg_pkg::sts_t sts,
  output mmvg_pkg::cmd_t cmd
);
  import mmvg_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOLD
  } state_t;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  state_t           state;
  logic [CNT_W-1:0] cnt;

  // Commands
  assign in_ready     = (state == S_IDLE);
  assign cmd.take     = in_valid && in_ready;
  assign cmd.div_step = (state == S_DIV);
  assign cmd.out_load = (state == S_HOLD) && (!out_valid || out_ready);

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.take) begin
            cnt   <= '0;
            state <= sts.random_mode ? S_DIV : S_HOLD;
          end
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) state <= S_HOLD;
        end
        S_HOLD: begin
          if (cmd.out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ----- design/mmvg_datapath.sv -----
module mmvg_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mmvg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mmvg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [mmvg_pkg::RND_W-1:0]        random_word,
  output logic [mmvg_pkg::VAL_W-1:0]        value_out,
  input  mmvg_pkg::cmd_t                    cmd,
  output mmvg_pkg::sts_t                    sts
);
  import mmvg_pkg::*;

  // Configuration registers
  mode_t            mode, mode_next;
  logic             sgn, sgn_next;
  logic [VAL_W-1:0] min_v, min_next;
  logic [VAL_W-1:0] max_v, max_next;
  logic [VAL_W-1:0] step, step_next;
  logic             reload;

  // Working state
  logic [VAL_W-1:0]  cur_val;
  logic [VAL_W-1:0]  cur_step;
  logic [VAL_W-1:0]  res;
  logic [RND_W-1:0]  dividend;
  logic [SPAN_W-1:0] rem;
  logic [SPAN_W-1:0] span;

  logic [VAL_W-1:0]  sum, val_next, step_upd;
  logic [VAL_W-1:0]  key_sum, key_min, key_max, span16;
  logic              below, above;
  logic [SPAN_W:0]   shifted;

  assign sts.random_mode = (mode == MODE_RANDOM);

  // Register write decode
  always_comb begin
    mode_next = mode;
    sgn_next  = sgn;
    min_next  = min_v;
    max_next  = max_v;
    step_next = step;
    reload    = 1'b0;
    if (cfg_write) begin
      reload = 1'b1;
      unique case (cfg_index)
        REG_MODE:   mode_next = mode_t'(cfg_data[1:0]);
        REG_SIGNED: sgn_next  = cfg_data[0];
        REG_MIN:    min_next  = cfg_data[VAL_W-1:0];
        REG_MAX:    max_next  = cfg_data[VAL_W-1:0];
        REG_STEP:   step_next = cfg_data[VAL_W-1:0];
        default:    reload    = 1'b0;
      endcase
    end
  end

  // Sawtooth / triangle advance; sign flip turns signed order into unsigned
  always_comb begin
    sum      = cur_val + cur_step;
    key_sum  = sgn ? (sum   ^ 16'h8000) : sum;
    key_min  = sgn ? (min_v ^ 16'h8000) : min_v;
    key_max  = sgn ? (max_v ^ 16'h8000) : max_v;
    below    = key_sum < key_min;
    above    = key_sum > key_max;
    val_next = sum;
    step_upd = cur_step;
    if (below) begin
      if (mode == MODE_WRAP) begin
        val_next = max_v;
      end else begin
        val_next = min_v + 16'd1;
        step_upd = 16'd0 - cur_step;
      end
    end else if (above) begin
      if (mode == MODE_WRAP) begin
        val_next = min_v;
      end else begin
        val_next = max_v - 16'd1;
        step_upd = 16'd0 - cur_step;
      end
    end
  end

  // Random range: zero span means the full 16-bit range
  assign span16  = max_v - min_v + 16'd1;
  assign shifted = {rem, dividend[RND_W-1]};

  // Config and tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_CONST;
      sgn      <= 1'b0;
      min_v    <= '0;
      max_v    <= '1;
      step     <= 16'd1;
      cur_val  <= '0;
      cur_step <= 16'd1;
    end else begin
      mode  <= mode_next;
      sgn   <= sgn_next;
      min_v <= min_next;
      max_v <= max_next;
      step  <= step_next;
      if (reload) begin
        cur_val  <= min_next;
        cur_step <= step_next;
      end else if (cmd.take && (mode == MODE_WRAP || mode == MODE_PONG)) begin
        cur_val  <= val_next;
        cur_step <= step_upd;
      end
    end
  end

  // Result capture, remainder divider, output register
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      res      <= (mode == MODE_CONST) ? min_v : cur_val;
      dividend <= random_word;
      rem      <= '0;
      span     <= (span16 == '0) ? {1'b1, {VAL_W{1'b0}}} : {1'b0, span16};
    end
    if (cmd.div_step) begin
      dividend <= {dividend[RND_W-2:0], 1'b0};
      if (shifted >= {1'b0, span}) rem <= SPAN_W'(shifted - {1'b0, span});
      else rem <= shifted[SPAN_W-1:0];
    end
    if (cmd.out_load) begin
      value_out <= (mode == MODE_RANDOM) ? (min_v + rem[VAL_W-1:0]) : res;
    end
  end

endmodule

// ----- design/multi_mode_value_generator_core.sv -----
// Multi-mode value generator: constant, wrapping sawtooth, ping-pong
// triangle and random-in-range values, one 16-bit value per tick.
// Input channel (in_valid/in_ready/random_word): each beat is one tick;
// random_word is used only in random mode.
// Output channel (out_valid/out_ready/value_out): one beat per tick.
// Configuration: cfg_write/cfg_index/cfg_data write one register per cycle;
// index 0 mode, 1 signed compares, 2 min, 3 max, 4 step. Any valid write
// reloads the running value from min and the running step from step.
// Path: constant/sawtooth/triangle ticks go via the result register to the
// output register; random ticks also pass the 32-step restoring divider
// that forms random_word mod span, one bit a cycle. A new tick is taken
// only after the previous one has moved into the output register.
// The output register decouples the sides: a new tick is taken while the
// previous value waits; when the receiver stalls, the next finished value
// holds in the datapath and in_ready stays low until it moves out.
// Reset (rst, synchronous): registers return to constant mode, unsigned,
// min 0, max 0xFFFF, step 1; the output channel empties.
module multi_mode_value_generator_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mmvg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mmvg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mmvg_pkg::RND_W-1:0]       random_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mmvg_pkg::VAL_W-1:0]       value_out
);
  import mmvg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mmvg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mmvg_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .random_word (random_word),
    .value_out   (value_out),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
